// ===== rtl/dynamic_threshold_step_counter_core_macros.svh =====
// Assertion macros for the dynamic threshold step counter core.
`ifndef DYNAMIC_THRESHOLD_STEP_COUNTER_CORE_MACROS_SVH
`define DYNAMIC_THRESHOLD_STEP_COUNTER_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define DTSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define DTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dtsc_pkg.sv =====
// Package: widths, reset values and register indexes of the step counter core.
`default_nettype none
package dtsc_pkg;

  localparam int ACCEL_W    = 16;
  localparam int COUNT_W    = 32;
  localparam int WLEN_W     = 8;
  localparam int CHG_W      = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [WLEN_W-1:0]         WLEN_RESET    = 8'd50;
  localparam logic [CHG_W-1:0]          CHG_RESET     = 15'd30;
  localparam logic signed [ACCEL_W-1:0] PEAK_MAX_INIT = -16'sd20;
  localparam logic signed [ACCEL_W-1:0] PEAK_MIN_INIT = 16'sd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH    = 1'b0,
    CFG_CHANGE_THRESHOLD = 1'b1
  } cfg_idx_t;

endpackage
`default_nettype wire

// ===== rtl/dynamic_threshold_step_counter_core.sv =====
// Top level: dynamic threshold step counter, one accelerometer word per cycle while in_stall is low.
//
//   channel | ports                                      | handshake
//   --------+--------------------------------------------+-------------------
//   in      | in_valid, in_stall, in_accel_mg[15:0] s    | valid && !stall
//   out     | out_valid, out_stall, out_step_total[31:0] | valid && !stall
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | valid && ready
//
// One input word per clock while in_stall is low: all peak, filter and threshold
// work is combinational between the input port and the result register, which
// registers the step total (or the skid entry does, while the result is stalled).
// rst_n (synchronous, active low) clears the peak, filter and count state and
// restores window_length = 50 and change_threshold = 30.
// A one-entry skid register behind the result register keeps accepting while
// out_stall is high; in_stall rises only once the skid entry is occupied.
`default_nettype none
`include "dynamic_threshold_step_counter_core_macros.svh"
module dynamic_threshold_step_counter_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // sample channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [dtsc_pkg::ACCEL_W-1:0]   in_accel_mg,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [dtsc_pkg::COUNT_W-1:0]               out_step_total,
  // configuration channel
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [dtsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dtsc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int AW = dtsc_pkg::ACCEL_W;
  localparam int WW = dtsc_pkg::WLEN_W;
  localparam int CW = dtsc_pkg::COUNT_W;

  // configuration registers
  logic [WW-1:0]                 wlen_r;
  logic [dtsc_pkg::CHG_W-1:0]    chg_r;

  // algorithm state
  logic [WW-1:0]                 win_cnt_r, win_cnt_nxt;
  logic signed [AW-1:0]          run_max_r, run_max_nxt;
  logic signed [AW-1:0]          run_min_r, run_min_nxt;
  logic signed [AW-1:0]          prev_max_r, prev_max_nxt;
  logic signed [AW-1:0]          prev_min_r, prev_min_nxt;
  logic signed [AW-1:0]          filt_cur_r, filt_cur_nxt;
  logic signed [AW-1:0]          filt_prev_r;
  logic [CW-1:0]                 step_cnt_r, step_cnt_nxt;

  // output register and skid entry
  logic                          out_valid_r, skid_valid_r;
  logic [CW-1:0]                 out_data_r, skid_data_r;

  logic                          in_fire, out_fire;
  logic [WW:0]                   win_next;
  logic                          roll;
  logic signed [AW-1:0]          base_max, base_min;
  logic signed [AW:0]            diff;
  logic [AW:0]                   diff_mag;
  logic signed [AW:0]            peak_sum, peak_half;
  logic signed [AW-1:0]          thr;
  logic                          step_hit;

  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_step_total = out_data_r;

  // Window counter: count at one extra bit so a length of 255 still rolls.
  always_comb begin
    win_next    = {1'b0, win_cnt_r} + {{WW{1'b0}}, 1'b1};
    roll        = win_next > {1'b0, wlen_r};
    win_cnt_nxt = roll ? {{(WW-1){1'b0}}, 1'b1} : win_next[WW-1:0];
  end

  // Peak tracking: on rollover, copy the running pair back and restart it.
  always_comb begin
    prev_max_nxt = roll ? run_max_r : prev_max_r;
    prev_min_nxt = roll ? run_min_r : prev_min_r;
    base_max     = roll ? dtsc_pkg::PEAK_MAX_INIT : run_max_r;
    base_min     = roll ? dtsc_pkg::PEAK_MIN_INIT : run_min_r;
    run_max_nxt  = (in_accel_mg > base_max) ? in_accel_mg : base_max;
    run_min_nxt  = (in_accel_mg < base_min) ? in_accel_mg : base_min;
  end

  // Change filter: exact 17-bit difference, load the sample on a large move.
  always_comb begin
    diff         = {in_accel_mg[AW-1], in_accel_mg} - {filt_cur_r[AW-1], filt_cur_r};
    diff_mag     = diff[AW] ? $unsigned(-diff) : $unsigned(diff);
    filt_cur_nxt = (diff_mag > {2'b00, chg_r}) ? in_accel_mg : filt_cur_r;
  end

  // Threshold is the midpoint of the previous peaks, rounded toward zero.
  always_comb begin
    peak_sum  = {prev_max_nxt[AW-1], prev_max_nxt} + {prev_min_nxt[AW-1], prev_min_nxt};
    peak_half = (peak_sum + {{AW{1'b0}}, peak_sum[AW]}) >>> 1;
    thr       = peak_half[AW-1:0];
    // The old current value becomes the previous filtered value.
    step_hit     = (filt_cur_r > thr) && (filt_cur_nxt < thr);
    step_cnt_nxt = step_cnt_r + {{(CW-1){1'b0}}, step_hit};
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= dtsc_pkg::WLEN_RESET;
      chg_r  <= dtsc_pkg::CHG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (dtsc_pkg::cfg_idx_t'(cfg_index))
        dtsc_pkg::CFG_WINDOW_LENGTH:    wlen_r <= cfg_data[WW-1:0];
        dtsc_pkg::CFG_CHANGE_THRESHOLD: chg_r  <= cfg_data[dtsc_pkg::CHG_W-1:0];
        default: ;
      endcase
    end
  end

  // Algorithm state: advance on every accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cnt_r   <= '0;
      run_max_r   <= dtsc_pkg::PEAK_MAX_INIT;
      run_min_r   <= dtsc_pkg::PEAK_MIN_INIT;
      prev_max_r  <= dtsc_pkg::PEAK_MAX_INIT;
      prev_min_r  <= dtsc_pkg::PEAK_MIN_INIT;
      filt_cur_r  <= '0;
      filt_prev_r <= '0;
      step_cnt_r  <= '0;
    end else if (in_fire) begin
      win_cnt_r   <= win_cnt_nxt;
      run_max_r   <= run_max_nxt;
      run_min_r   <= run_min_nxt;
      prev_max_r  <= prev_max_nxt;
      prev_min_r  <= prev_min_nxt;
      filt_cur_r  <= filt_cur_nxt;
      filt_prev_r <= filt_cur_r;
      step_cnt_r  <= step_cnt_nxt;
    end
  end

  // Result register with skid entry: drain skid first, keep word order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_data_r <= skid_valid_r ? skid_data_r : step_cnt_nxt;
    end
    if (out_valid_r && !out_fire && in_fire) begin
      skid_data_r <= step_cnt_nxt;
    end
  end

  // Assertions
  `DTSC_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r, "skid holds a word while output register is empty")
  `DTSC_ASSERT_NEXT(a_skid_fill, out_valid_r && out_stall && in_fire, skid_valid_r, "stalled result plus new word did not fill skid")
  `DTSC_ASSERT_NEXT(a_count_hold, !in_fire, step_cnt_r == $past(step_cnt_r), "step count moved without an accepted word")
  `DTSC_ASSERT_NEXT(a_peak_order, in_fire, run_max_r >= run_min_r, "running max fell below running min")

  // filt_prev_r mirrors the model's previous filtered slot.
  `DTSC_ASSERT_NEXT(a_filt_shift, in_fire, filt_prev_r == $past(filt_cur_r), "filter slots did not shift")

endmodule
`default_nettype wire
